>>> rtl/bpec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared types and constants of the button press event classifier.
// ----------------------------------------------------------------------------
package bpec_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FIFO_AW   = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;
  localparam int unsigned FIFO_CW   = FIFO_AW + 1;

  localparam logic [CNT_W-1:0]  CNT_MAX             = 4'd15;
  localparam logic [TIME_W-1:0] SAMPLE_INTERVAL_RST = 32'd20;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_MODE      = 3'd0,
    REG_ACTIVE_LEVEL    = 3'd1,
    REG_SAMPLE_INTERVAL = 3'd2,
    REG_DOUBLE_WINDOW   = 3'd3,
    REG_LONG_HOLD       = 3'd4,
    REG_SINGLE_ENABLE   = 3'd5,
    REG_DOUBLE_ENABLE   = 3'd6,
    REG_LONG_ENABLE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              input_mode;
    logic              active_level;
    logic [TIME_W-1:0] sample_interval;
    logic [TIME_W-1:0] double_window;
    logic [TIME_W-1:0] long_hold;
    logic              single_enable;
    logic              double_enable;
    logic              long_enable;
  } cfg_t;

  // Events raised by one sample: count (0 to 2) and their kinds in order.
  typedef struct packed {
    logic [1:0] n;
    kind_t      kind0;
    kind_t      kind1;
  } res_t;

endpackage

>>> rtl/bpec_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpec_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module bpec_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [bpec_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [bpec_pkg::TIME_W-1:0]       wr_data,
  output bpec_pkg::cfg_t                    cfg
);
  import bpec_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_idx))
        REG_INPUT_MODE:      cfg_nxt.input_mode      = wr_data[0];
        REG_ACTIVE_LEVEL:    cfg_nxt.active_level    = wr_data[0];
        REG_SAMPLE_INTERVAL: cfg_nxt.sample_interval = wr_data;
        REG_DOUBLE_WINDOW:   cfg_nxt.double_window   = wr_data;
        REG_LONG_HOLD:       cfg_nxt.long_hold       = wr_data;
        REG_SINGLE_ENABLE:   cfg_nxt.single_enable   = wr_data[0];
        REG_DOUBLE_ENABLE:   cfg_nxt.double_enable   = wr_data[0];
        REG_LONG_ENABLE:     cfg_nxt.long_enable     = wr_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{input_mode:      1'b0,
                 active_level:    1'b0,
                 sample_interval: SAMPLE_INTERVAL_RST,
                 double_window:   '0,
                 long_hold:       '0,
                 single_enable:   1'b0,
                 double_enable:   1'b0,
                 long_enable:     1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bpec_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpec_classify
// Button state and press classification for one registered sample.
// ----------------------------------------------------------------------------
module bpec_classify (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpec_pkg::cfg_t               cfg,
  input  logic                         smp_go,
  input  logic                         smp_level,
  input  logic [bpec_pkg::TIME_W-1:0]  smp_now,
  output bpec_pkg::res_t               res
);
  import bpec_pkg::*;

  logic              pnow_r, pnow_nxt;
  logic              arm_r, arm_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] first_r, first_nxt;
  logic [TIME_W-1:0] hold_r, hold_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic              take;
  logic              pressed;
  logic              done;
  logic              dbl_open;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] first;
  logic [TIME_W-1:0] hold;
  logic              arm;
  res_t              r;

  // The previous pressed state is pnow_r itself: it becomes pressed_before
  // as soon as a new sample is taken.
  always_comb begin
    take    = cfg.input_mode | ((smp_now - last_r) >= cfg.sample_interval);
    pressed = cfg.input_mode ? smp_level : (smp_level == cfg.active_level);

    pnow_nxt    = pnow_r;
    arm_nxt     = arm_r;
    cnt_nxt     = cnt_r;
    first_nxt   = first_r;
    hold_nxt    = hold_r;
    last_nxt    = last_r;

    cnt      = cnt_r;
    first    = first_r;
    hold     = hold_r;
    arm      = arm_r;
    done     = 1'b0;
    dbl_open = 1'b0;
    r        = '{n: 2'd0, kind0: KIND_SINGLE, kind1: KIND_SINGLE};

    if (smp_go && take) begin
      pnow_nxt    = pressed;
      if (!cfg.input_mode) begin
        last_nxt = smp_now;
      end

      // Press edge: arm debounce only
      if (!pnow_r && pressed) begin
        arm  = 1'b1;
        done = 1'b1;
      end

      if (!done) begin
        // Single timeout
        dbl_open = cfg.double_enable && ((smp_now - first) <= cfg.double_window);
        if ((cnt != '0) && !dbl_open &&
            !(cfg.long_enable && (hold != '0) && pressed)) begin
          if (cfg.single_enable) begin
            r.kind0 = KIND_SINGLE;
            r.n     = 2'd1;
          end
          cnt   = '0;
          first = '0;
        end

        if (pnow_r && pressed) begin
          if (arm) begin
            if (cnt != CNT_MAX) begin
              cnt = cnt + 1'b1;
            end
            if (first == '0) begin
              first = smp_now;
            end
            if (hold == '0) begin
              hold = smp_now;
            end
            arm = 1'b0;
          end
          if (cfg.long_enable && (cnt != '0) &&
              ((smp_now - hold) >= cfg.long_hold)) begin
            if (r.n == 2'd0) begin
              r.kind0 = KIND_LONG;
              r.n     = 2'd1;
            end else begin
              r.kind1 = KIND_LONG;
              r.n     = 2'd2;
            end
            cnt   = '0;
            first = '0;
            hold  = '0;
            done  = 1'b1;
          end else if (cfg.double_enable && (cnt > 4'd1) &&
                       ((smp_now - first) <= cfg.double_window)) begin
            if (r.n == 2'd0) begin
              r.kind0 = KIND_DOUBLE;
              r.n     = 2'd1;
            end else begin
              r.kind1 = KIND_DOUBLE;
              r.n     = 2'd2;
            end
            cnt   = '0;
            first = '0;
            done  = 1'b1;
          end
        end

        // Release drops the hold stamp
        if (!done && pnow_r && !pressed) begin
          hold = '0;
        end
      end

      arm_nxt   = arm;
      cnt_nxt   = cnt;
      first_nxt = first;
      hold_nxt  = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnow_r    <= 1'b0;
      arm_r     <= 1'b0;
      cnt_r     <= '0;
      first_r   <= '0;
      hold_r    <= '0;
      last_r    <= '0;
    end else begin
      pnow_r    <= pnow_nxt;
      arm_r     <= arm_nxt;
      cnt_r     <= cnt_nxt;
      first_r   <= first_nxt;
      hold_r    <= hold_nxt;
      last_r    <= last_nxt;
    end
  end

  assign res = r;

endmodule

>>> rtl/bpec_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpec_out_fifo
// Event queue: takes up to two events per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module bpec_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  bpec_pkg::res_t                 res,
  input  logic                           pop,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic                           out_last,
  output logic [bpec_pkg::FIFO_CW-1:0]   count
);
  import bpec_pkg::*;

  logic [2:0]         ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]         n_push;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign n_push     = push ? res.n : 2'd0;
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign cnt_nxt    = cnt_r + FIFO_CW'(n_push) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      ent_r[wr_ptr_r] <= {res.kind0, (n_push == 2'd1)};
    end
    if (n_push == 2'd2) begin
      ent_r[wr_ptr_p1] <= {res.kind1, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_kind  = ent_r[rd_ptr_r][2:1];
  assign out_last  = ent_r[rd_ptr_r][0];
  assign count     = cnt_r;

endmodule

>>> rtl/button_press_event_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_event_classifier
// Debounces timestamped button samples and reports single, double and long
// press events.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in_      | in_valid / in_stall  | in_level, in_now_ms
//  out_     | out_valid / out_stall| out_event_kind, out_last_event
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle while in_stall is low: it is held in the input
// register, classified there and its events (up to two) land in a
// four-entry queue; events are driven out from the queue registers.
// A sample leaves the input register only when the queue holds two or fewer
// events, so in_stall rises only while the event queue backs up.
// Synchronous active-low reset; configuration is always ready.
// ----------------------------------------------------------------------------
module button_press_event_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_level,
  input  logic [bpec_pkg::TIME_W-1:0]      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_event_kind,
  output logic                             out_last_event,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpec_pkg::TIME_W-1:0]      cfg_data
);
  import bpec_pkg::*;

  cfg_t               cfg;
  res_t               res;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_level_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_go;
  logic               in_take;
  logic               pop;
  logic [FIFO_CW-1:0] q_count;

  assign cfg_ready = 1'b1;

  bpec_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Advance the input register only when the queue can take two events
  assign s1_go    = s1_valid_r && (q_count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign s1_valid_nxt = in_take | (s1_valid_r & ~s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_level;
      s1_now_r   <= in_now_ms;
    end
  end

  bpec_classify u_cls (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_go    (s1_go),
    .smp_level (s1_level_r),
    .smp_now   (s1_now_r),
    .res       (res)
  );

  assign pop = out_valid && !out_stall;

  bpec_out_fifo u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_go),
    .res       (res),
    .pop       (pop),
    .out_valid (out_valid),
    .out_kind  (out_event_kind),
    .out_last  (out_last_event),
    .count     (q_count)
  );

`ifndef SYNTH
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("event queue overflow");

  a_pair_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_event && !out_stall) |=> out_valid)
    else $error("second event of a sample missing");

  a_reset_open : assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_stall)
    else $error("input stalled right after reset");

  a_kind_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind != 2'd3))
    else $error("illegal event kind at output");
`endif

endmodule

>>> sim/button_press_event_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_event_classifier_test
// Self-checking bench for the button press event classifier. A behavioral
// copy of the classifier predicts the events of every sample transfer; each
// event transfer is matched, in order, against the oldest prediction. Directed
// press patterns come first, then randomized press/hold/release sequences
// under a series of register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module button_press_event_classifier_test;
  import bpec_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned MAX_PHASES    = 24;
  localparam int unsigned PHASE_ITEMS   = 85;

  typedef struct {
    kind_t kind;
    logic  last;
  } event_exp_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_level   = 1'b0;
  logic [TIME_W-1:0]    in_now_ms  = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [TIME_W-1:0]    cfg_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           out_event_kind;
  logic                 out_last_event;
  logic                 cfg_ready;

  // predictor copy of the registers and the classifier state
  cfg_t                 settings;
  logic                 st_pressed_now;
  logic                 st_pressed_before;
  logic                 st_armed;
  logic [CNT_W-1:0]     st_count;
  logic [TIME_W-1:0]    st_first;
  logic [TIME_W-1:0]    st_hold;
  logic [TIME_W-1:0]    st_last_sample;

  event_exp_t           expected_events[$];
  event_exp_t           head_event;
  logic [TIME_W-1:0]    clock_ms;
  logic                 steady = 1'b0;
  int unsigned          samples_used = 0;
  int unsigned          failures = 0;
  int unsigned          quiet_cycles = 0;

  button_press_event_classifier i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_level       (in_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    settings                 = '0;
    settings.sample_interval = SAMPLE_INTERVAL_RST;
    st_pressed_now           = 1'b0;
    st_pressed_before        = 1'b0;
    st_armed                 = 1'b0;
    st_count                 = '0;
    st_first                 = '0;
    st_hold                  = '0;
    st_last_sample           = '0;
  endfunction

  function automatic res_t with_event(input res_t r, input kind_t k);
    if (r.n == 2'd0) r.kind0 = k;
    else r.kind1 = k;
    r.n = r.n + 2'd1;
    return r;
  endfunction

  function automatic res_t classify_sample(input logic [TIME_W-1:0] now);
    res_t r;
    r = '0;
    // a fresh press only arms the debounce
    if (!st_pressed_before && st_pressed_now) begin
      st_armed = 1'b1;
      return r;
    end
    if (st_count != '0 &&
        !(settings.double_enable && (now - st_first) <= settings.double_window) &&
        !(settings.long_enable && st_hold != '0 && st_pressed_now)) begin
      if (settings.single_enable) r = with_event(r, KIND_SINGLE);
      st_count = '0;
      st_first = '0;
    end
    if (st_pressed_before && st_pressed_now) begin
      if (st_armed) begin
        if (st_count < CNT_MAX) st_count = st_count + 1'b1;
        if (st_first == '0) st_first = now;
        if (st_hold == '0) st_hold = now;
        st_armed = 1'b0;
      end
      if (settings.long_enable && st_count != '0 && (now - st_hold) >= settings.long_hold) begin
        st_count = '0;
        st_first = '0;
        st_hold  = '0;
        return with_event(r, KIND_LONG);
      end
      if (settings.double_enable && st_count > 1 &&
          (now - st_first) <= settings.double_window) begin
        st_count = '0;
        st_first = '0;
        return with_event(r, KIND_DOUBLE);
      end
    end
    if (st_pressed_before && !st_pressed_now) st_hold = '0;
    return r;
  endfunction

  function automatic void predict_sample(input logic lvl, input logic [TIME_W-1:0] now);
    logic       pressed;
    res_t       r;
    event_exp_t e;
    if (!settings.input_mode) begin
      // drop samples that come before the interval is up
      if ((now - st_last_sample) < settings.sample_interval) return;
      st_last_sample = now;
      pressed = (lvl == settings.active_level);
    end else begin
      pressed = lvl;
    end
    st_pressed_before = st_pressed_now;
    st_pressed_now    = pressed;
    r = classify_sample(now);
    if (r.n >= 2'd1) begin
      e.kind = r.kind0;
      e.last = (r.n == 2'd1);
      expected_events.push_back(e);
    end
    if (r.n == 2'd2) begin
      e.kind = r.kind1;
      e.last = 1'b1;
      expected_events.push_back(e);
    end
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_level  <= lvl;
    in_now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_used++;
    predict_sample(lvl, now);
  endtask

  // hold cfg_valid high across back-to-back writes; apply_settings lowers it
  task automatic write_reg(input reg_idx_t idx, input logic [TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] flag_word(input logic b);
    logic [TIME_W-1:0] w;
    w    = $urandom;
    w[0] = b;
    return w;
  endfunction

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_INPUT_MODE, flag_word(s.input_mode));
    write_reg(REG_ACTIVE_LEVEL, flag_word(s.active_level));
    write_reg(REG_SAMPLE_INTERVAL, s.sample_interval);
    write_reg(REG_DOUBLE_WINDOW, s.double_window);
    write_reg(REG_LONG_HOLD, s.long_hold);
    write_reg(REG_SINGLE_ENABLE, flag_word(s.single_enable));
    write_reg(REG_DOUBLE_ENABLE, flag_word(s.double_enable));
    write_reg(REG_LONG_ENABLE, flag_word(s.long_enable));
    cfg_valid <= 1'b0;
    settings = s;
  endtask

  // wait for all predicted events, then let in-flight samples with no event pass
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] next_gap(input logic [TIME_W-1:0] span);
    int unsigned r;
    r = $urandom_range(99);
    // with a huge interval only a gap of exactly the interval gets through
    if (settings.sample_interval > 32'h000F_FFFF && r < 70) return settings.sample_interval;
    if (r < 4) return $urandom;
    if (r < 14) return $urandom_range(40);
    if (r < 35 && span < 32'h000F_FFFF) return span + $urandom_range(20);
    return settings.sample_interval + $urandom_range(30);
  endfunction

  task automatic send_timed(input logic pressed, input logic [TIME_W-1:0] gap);
    logic lvl;
    if ($urandom_range(99) < 2) clock_ms = '0;
    else clock_ms = clock_ms + gap;
    lvl = settings.input_mode ? pressed : (pressed ~^ settings.active_level);
    send_sample(lvl, clock_ms);
  endtask

  task automatic send_press_sequence();
    int unsigned releases;
    int unsigned holds;
    releases = $urandom_range(1, 3);
    holds    = $urandom_range(1, 6);
    repeat (releases) send_timed(1'b0, next_gap(settings.double_window));
    repeat (holds) send_timed(1'b1, next_gap(settings.long_hold));
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_sample(1'b0, 32'd5);          // rejected: interval not yet elapsed
    send_sample(1'b1, 32'hFFFF_FFFF);  // accepted, released
    send_sample(1'b0, 32'h0000_0013);  // interval exactly met, press edge
    drain();
  endtask

  task automatic test_press_events();
    cfg_t s;
    s                 = '0;
    s.input_mode      = 1'b1;
    s.sample_interval = 32'd1;
    s.double_window   = 32'd100;
    s.long_hold       = 32'd500;
    s.single_enable   = 1'b1;
    s.double_enable   = 1'b1;
    s.long_enable     = 1'b1;
    apply_settings(s);
    // single: one press, then wait out the double window
    send_sample(1'b0, 32'd1000);
    send_sample(1'b1, 32'd1010);
    send_sample(1'b1, 32'd1020);
    send_sample(1'b0, 32'd1030);
    send_sample(1'b0, 32'd1300);
    // double: two confirmed presses inside the window
    send_sample(1'b1, 32'd1310);
    send_sample(1'b1, 32'd1320);
    send_sample(1'b0, 32'd1330);
    send_sample(1'b1, 32'd1340);
    send_sample(1'b1, 32'd1350);
    // long: confirm, then keep holding past long_hold
    send_sample(1'b0, 32'd2000);
    send_sample(1'b1, 32'd2010);
    send_sample(1'b1, 32'd2020);
    send_sample(1'b1, 32'd2600);
    drain();
  endtask

  task automatic test_single_then_long();
    cfg_t s;
    s                 = '0;
    s.input_mode      = 1'b1;
    s.sample_interval = 32'hFFFF_FFFF;
    s.double_window   = 32'd50;
    s.long_hold       = 32'd0;
    s.single_enable   = 1'b1;
    s.double_enable   = 1'b1;
    apply_settings(s);
    // leave one press counted, released inside the window
    send_sample(1'b0, 32'd5000);
    send_sample(1'b1, 32'd5010);
    send_sample(1'b1, 32'd5020);
    send_sample(1'b0, 32'd5030);
    drain();
    s.long_enable = 1'b1;
    apply_settings(s);
    // the late confirm times out the old press and is itself a long press
    send_sample(1'b1, 32'd5300);
    send_sample(1'b1, 32'd5310);
    drain();
  endtask

  task automatic test_time_zero();
    cfg_t s;
    s           = settings;
    s.long_hold = 32'd100;
    apply_settings(s);
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'hFFFF_FFFA);
    send_sample(1'b1, 32'h0000_0000);  // confirmed at zero: stamps stay unset
    drain();
  endtask

  task automatic test_random_sequences();
    cfg_t        s;
    int unsigned phase;
    int unsigned target;
    phase = 0;
    while (samples_used < RANDOM_ITEMS + 26 && phase < MAX_PHASES) begin
      drain();
      case (phase)
        0: begin
          s                 = '0;
          s.active_level    = 1'b1;
          s.sample_interval = 32'd0;
          s.double_window   = 32'hFFFF_FFFF;
          s.long_hold       = 32'hFFFF_FFFF;
          s.single_enable   = 1'b1;
          s.double_enable   = 1'b1;
          s.long_enable     = 1'b1;
        end
        1: begin
          s               = '0;
          s.input_mode    = 1'b1;
          s.single_enable = 1'b1;
          s.double_enable = 1'b1;
          s.long_enable   = 1'b1;
        end
        default: begin
          s.input_mode   = 1'($urandom_range(1));
          s.active_level = 1'($urandom_range(1));
          case ($urandom_range(9))
            0:       s.sample_interval = 32'd0;
            1:       s.sample_interval = 32'hFFFF_FFFF;
            default: s.sample_interval = $urandom_range(1, 30);
          endcase
          case ($urandom_range(9))
            0:       s.double_window = 32'd0;
            1:       s.double_window = 32'hFFFF_FFFF;
            default: s.double_window = $urandom_range(10, 300);
          endcase
          case ($urandom_range(9))
            0:       s.long_hold = 32'd0;
            1:       s.long_hold = 32'hFFFF_FFFF;
            default: s.long_hold = $urandom_range(20, 600);
          endcase
          s.single_enable = ($urandom_range(3) != 0);
          s.double_enable = ($urandom_range(3) != 0);
          s.long_enable   = ($urandom_range(3) != 0);
        end
      endcase
      apply_settings(s);
      clock_ms = $urandom;
      steady   = (phase == 3);
      target   = samples_used + PHASE_ITEMS;
      while (samples_used < target) begin
        if ($urandom_range(99) < 85) begin
          send_press_sequence();
        end else begin
          repeat ($urandom_range(1, 4))
            send_timed(1'($urandom_range(1)), next_gap(32'hFFFF_FFFF));
        end
      end
      phase++;
    end
    steady = 1'b0;
    drain();
  endtask

  // ----------------------------------------------------------------- checking

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event transfer: event_kind %0d last_event %0d",
               out_event_kind, out_last_event);
        failures++;
      end else begin
        head_event = expected_events.pop_front();
        if (out_event_kind !== head_event.kind) begin
          $error("event_kind: expected %0d, actual %0d", head_event.kind, out_event_kind);
          failures++;
        end
        if (out_last_event !== head_event.last) begin
          $error("last_event: expected %0d, actual %0d", head_event.last, out_last_event);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_press_events();
    test_single_then_long();
    test_time_zero();
    test_random_sequences();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
